// ===== sv/fifo_mutex_with_condition_queue_defines.svh =====
// Assertion macros used by fmcq_checker.
`ifndef FIFO_MUTEX_WITH_CONDITION_QUEUE_DEFINES_SVH
`define FIFO_MUTEX_WITH_CONDITION_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define FMCQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fmcq assertion failed");

// Implication checked in the next cycle.
`define FMCQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fmcq assertion failed");

// Implication with consequent delayed by dly.
`define FMCQ_ASSERT_LAT(lbl, ck, rn, ante, dly, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##dly (cons)) \
    else $error("fmcq assertion failed");

`endif

// ===== sv/fmcq_pkg.sv =====
package fmcq_pkg;

  localparam int MUTEX_DEPTH_DEF = 16;
  localparam int COND_DEPTH_DEF  = 16;
  localparam int TID_BITS_DEF    = 8;

  // Most wakeups one notify-all request reports.
  localparam int MAX_RESULTS = 16;
  localparam int DRAIN_W     = $clog2(MAX_RESULTS);

  localparam int OP_W = 3;
  localparam int ST_W = 3;

  localparam logic [OP_W-1:0] OP_LOCK       = 3'd0;
  localparam logic [OP_W-1:0] OP_UNLOCK     = 3'd1;
  localparam logic [OP_W-1:0] OP_WAIT       = 3'd2;
  localparam logic [OP_W-1:0] OP_NOTIFY_ONE = 3'd3;
  localparam logic [OP_W-1:0] OP_NOTIFY_ALL = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
  localparam logic [ST_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [ST_W-1:0] ST_ALREADY   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic single;
    logic full;
  } q_stat_t;

endpackage

// ===== sv/fmcq_cell.sv =====
module fmcq_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] din,
  input  logic [W-1:0] from_next,
  output logic [W-1:0] q
);

  logic [W-1:0] data_r;

  // Advance toward the head on a pop, otherwise take a pushed id.
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= from_next;
    end else if (load) begin
      data_r <= din;
    end
  end

  assign q = data_r;

endmodule

// ===== sv/fmcq_queue.sv =====
module fmcq_queue import fmcq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  q_ctrl_t      ctrl,
  input  logic [W-1:0] din,
  output logic [W-1:0] head,
  output q_stat_t      stat
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [W-1:0]     data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] nxt_data;
    if (i == DEPTH - 1) begin : g_tail
      assign nxt_data = '0;
    end else begin : g_mid
      assign nxt_data = data[i+1];
    end
    fmcq_cell #(.W(W)) u_cell (
      .clk       (clk),
      .shift     (ctrl.pop),
      .load      (ctrl.push && (count_r == CNT_W'(i))),
      .din       (din),
      .from_next (nxt_data),
      .q         (data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head        = data[0];
  assign stat.empty  = (count_r == '0);
  assign stat.single = (count_r == CNT_W'(1));
  assign stat.full   = (count_r == CNT_W'(DEPTH));

endmodule

// ===== sv/fifo_mutex_with_condition_queue.sv =====
// Hardware lock unit: one FIFO hand-off mutex plus one FIFO condition queue.
// Request side: raise start with in_op and in_thread_id while busy is low;
// the beat is taken at that clock edge and busy rises for the work.
// Result side: each result beat sits on the out_ ports for one cycle with
// out_valid high; out_last marks the final beat of a request.
// A taken request enters S_EXEC; the first result is registered from there.
// No request is taken while busy is high; busy falls in the cycle the
// final result is shown, so a new request may be taken right then.
// Notify-all drains the condition queue one waiter per cycle, up to
// MAX_RESULTS beats, while busy stays high.
// Both waiter queues are chains of cells that shift toward the head on a
// pop, so the oldest waiter always sits in the first cell.
// Reset (rst_n low, synchronous): mutex free, owner zero, both queues empty,
// no result pending. No clearing pass is needed.
// The receiver cannot stall: every result is taken the cycle it is shown.
module fifo_mutex_with_condition_queue import fmcq_pkg::*; #(
  parameter int MUTEX_QUEUE_DEPTH = MUTEX_DEPTH_DEF,
  parameter int COND_QUEUE_DEPTH  = COND_DEPTH_DEF,
  parameter int THREAD_ID_BITS    = TID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_op,
  input  logic [THREAD_ID_BITS-1:0] in_thread_id,
  output logic                      out_valid,
  output logic [ST_W-1:0]           out_status,
  output logic                      out_wake_valid,
  output logic [THREAD_ID_BITS-1:0] out_wake_thread,
  output logic                      out_lock_held,
  output logic [THREAD_ID_BITS-1:0] out_owner_thread,
  output logic                      out_last
);

  localparam int TW = THREAD_ID_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r;
  logic [TW-1:0]      tid_r;
  logic               lock_r, lock_nxt;
  logic [TW-1:0]      owner_r, owner_nxt;
  logic [DRAIN_W-1:0] n_r, n_nxt;

  // Result being formed this cycle.
  logic               emit;
  logic [ST_W-1:0]    st;
  logic               wv;
  logic [TW-1:0]      wt;
  logic               lst;
  logic               release_req;
  logic               owns;

  q_ctrl_t       mq_ctl, cq_ctl;
  q_stat_t       mq_stat, cq_stat;
  logic [TW-1:0] mq_head, cq_head;

  fmcq_queue #(.DEPTH(MUTEX_QUEUE_DEPTH), .W(TW)) u_mutex_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mq_ctl),
    .din   (tid_r),
    .head  (mq_head),
    .stat  (mq_stat)
  );

  fmcq_queue #(.DEPTH(COND_QUEUE_DEPTH), .W(TW)) u_cond_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cq_ctl),
    .din   (tid_r),
    .head  (cq_head),
    .stat  (cq_stat)
  );

  assign owns = lock_r && (owner_r == tid_r);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    lock_nxt    = lock_r;
    owner_nxt   = owner_r;
    n_nxt       = n_r;
    mq_ctl      = '0;
    cq_ctl      = '0;
    emit        = 1'b0;
    st          = ST_DONE;
    wv          = 1'b0;
    wt          = '0;
    lst         = 1'b1;
    release_req = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
        n_nxt     = '0;
        unique case (op_r)
          OP_LOCK: begin
            if (owns) begin
              st = ST_ALREADY;
            end else if (!lock_r) begin
              lock_nxt  = 1'b1;
              owner_nxt = tid_r;
            end else if (mq_stat.full) begin
              st = ST_FULL;
            end else begin
              mq_ctl.push = 1'b1;
              st          = ST_BLOCKED;
            end
          end
          OP_UNLOCK: begin
            if (!owns) begin
              st = ST_NOT_OWNER;
            end else begin
              release_req = 1'b1;
            end
          end
          OP_WAIT: begin
            if (!owns) begin
              st = ST_NOT_OWNER;
            end else if (cq_stat.full) begin
              st = ST_FULL;
            end else begin
              release_req = 1'b1;
              cq_ctl.push = 1'b1;
              st          = ST_BLOCKED;
            end
          end
          OP_NOTIFY_ONE: begin
            if (!cq_stat.empty) begin
              cq_ctl.pop = 1'b1;
              wv         = 1'b1;
              wt         = cq_head;
            end
          end
          OP_NOTIFY_ALL: begin
            if (!cq_stat.empty) begin
              cq_ctl.pop = 1'b1;
              wv         = 1'b1;
              wt         = cq_head;
              lst        = cq_stat.single;
              if (!cq_stat.single) begin
                state_nxt = S_DRAIN;
                n_nxt     = DRAIN_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_DRAIN: begin
        emit       = 1'b1;
        cq_ctl.pop = 1'b1;
        wv         = 1'b1;
        wt         = cq_head;
        lst        = cq_stat.single || (n_r == DRAIN_W'(MAX_RESULTS - 1));
        n_nxt      = n_r + DRAIN_W'(1);
        state_nxt  = lst ? S_IDLE : S_DRAIN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Release: hand off to the oldest mutex waiter, or free the mutex.
    if (release_req) begin
      if (mq_stat.empty) begin
        lock_nxt  = 1'b0;
        owner_nxt = '0;
      end else begin
        owner_nxt  = mq_head;
        mq_ctl.pop = 1'b1;
        wv         = 1'b1;
        wt         = mq_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lock_r    <= 1'b0;
      owner_r   <= '0;
      n_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lock_r    <= lock_nxt;
      owner_r   <= owner_nxt;
      n_r       <= n_nxt;
      out_valid <= emit;
    end
  end

  // Latch the request beat; hold it through the work.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      op_r  <= in_op;
      tid_r <= in_thread_id;
    end
  end

  // Result register: shows lock state after this beat's update.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status       <= st;
      out_wake_valid   <= wv;
      out_wake_thread  <= wt;
      out_lock_held    <= lock_nxt;
      out_owner_thread <= lock_nxt ? owner_nxt : '0;
      out_last         <= lst;
    end
  end

endmodule

// ===== sv/fmcq_checker.sv =====
`include "fifo_mutex_with_condition_queue_defines.svh"

module fmcq_checker import fmcq_pkg::*; #(
  parameter int THREAD_ID_BITS = TID_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic                      out_lock_held,
  input logic [THREAD_ID_BITS-1:0] out_owner_thread,
  input logic                      out_last
);

  logic take;

  assign take = start && !busy;

  `FMCQ_ASSERT_NEXT(a_take_busy, clk, rst_n, take, busy)
  `FMCQ_ASSERT_LAT(a_first_result, clk, rst_n, take, 2, out_valid)
  `FMCQ_ASSERT_NOW(a_more_busy, clk, rst_n, out_valid && !out_last, busy)
  `FMCQ_ASSERT_NEXT(a_drain_b2b, clk, rst_n, out_valid && !out_last, out_valid)
  `FMCQ_ASSERT_NOW(a_free_owner, clk, rst_n, out_valid && !out_lock_held,
                   out_owner_thread == '0)

endmodule

bind fifo_mutex_with_condition_queue fmcq_checker #(
  .THREAD_ID_BITS (THREAD_ID_BITS)
) u_fmcq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_lock_held    (out_lock_held),
  .out_owner_thread (out_owner_thread),
  .out_last         (out_last)
);

// ===== tb/fmcq_grant_checker.sv =====
module fmcq_grant_checker import fmcq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [OP_W-1:0]         in_op,
  input  logic [TID_BITS_DEF-1:0] in_thread_id,
  input  logic                    out_valid,
  input  logic [ST_W-1:0]         out_status,
  input  logic                    out_wake_valid,
  input  logic [TID_BITS_DEF-1:0] out_wake_thread,
  input  logic                    out_lock_held,
  input  logic [TID_BITS_DEF-1:0] out_owner_thread,
  input  logic                    out_last,
  output int                      fail_count,
  output int                      beats_left
);

  typedef logic [TID_BITS_DEF-1:0] tid_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic            wake_valid;
    tid_t            wake_thread;
    logic            lock_held;
    tid_t            owner_thread;
    logic            last;
  } grant_beat_t;

  logic        locked;
  tid_t        owner;
  tid_t        mutex_line[$];
  tid_t        cond_line[$];
  grant_beat_t pending_beats[$];

  function automatic void queue_beat(input logic [ST_W-1:0] status, input logic woke,
                                     input tid_t who, input logic fin);
    grant_beat_t b;
    b.status       = status;
    b.wake_valid   = woke;
    b.wake_thread  = woke ? who : '0;
    b.lock_held    = locked;
    b.owner_thread = locked ? owner : '0;
    b.last         = fin;
    pending_beats.push_back(b);
  endfunction

  // Pass the mutex to the oldest waiter, or free it.
  function automatic void hand_off(output logic handed, output tid_t heir);
    heir = '0;
    if (mutex_line.size() == 0) begin
      locked = 1'b0;
      owner  = '0;
      handed = 1'b0;
    end else begin
      heir   = mutex_line.pop_front();
      owner  = heir;
      handed = 1'b1;
    end
  endfunction

  function automatic void grant_step(input logic [OP_W-1:0] op, input tid_t tid);
    logic is_owner;
    logic handed;
    tid_t heir;
    tid_t woken;
    int   n;
    is_owner = locked && owner == tid;
    case (op)
      OP_LOCK: begin
        if (is_owner) begin
          queue_beat(ST_ALREADY, 1'b0, '0, 1'b1);
        end else if (!locked) begin
          locked = 1'b1;
          owner  = tid;
          queue_beat(ST_DONE, 1'b0, '0, 1'b1);
        end else if (mutex_line.size() >= MUTEX_DEPTH_DEF) begin
          queue_beat(ST_FULL, 1'b0, '0, 1'b1);
        end else begin
          mutex_line.push_back(tid);
          queue_beat(ST_BLOCKED, 1'b0, '0, 1'b1);
        end
      end
      OP_UNLOCK: begin
        if (!is_owner) begin
          queue_beat(ST_NOT_OWNER, 1'b0, '0, 1'b1);
        end else begin
          hand_off(handed, heir);
          queue_beat(ST_DONE, handed, heir, 1'b1);
        end
      end
      OP_WAIT: begin
        if (!is_owner) begin
          queue_beat(ST_NOT_OWNER, 1'b0, '0, 1'b1);
        end else if (cond_line.size() >= COND_DEPTH_DEF) begin
          queue_beat(ST_FULL, 1'b0, '0, 1'b1);
        end else begin
          hand_off(handed, heir);
          cond_line.push_back(tid);
          queue_beat(ST_BLOCKED, handed, heir, 1'b1);
        end
      end
      OP_NOTIFY_ONE: begin
        if (cond_line.size() == 0) begin
          queue_beat(ST_DONE, 1'b0, '0, 1'b1);
        end else begin
          woken = cond_line.pop_front();
          queue_beat(ST_DONE, 1'b1, woken, 1'b1);
        end
      end
      OP_NOTIFY_ALL: begin
        if (cond_line.size() == 0) begin
          queue_beat(ST_DONE, 1'b0, '0, 1'b1);
        end else begin
          n = 0;
          while (cond_line.size() != 0 && n < MAX_RESULTS) begin
            woken = cond_line.pop_front();
            n++;
            queue_beat(ST_DONE, 1'b1, woken, cond_line.size() == 0 || n == MAX_RESULTS);
          end
        end
      end
      default: begin
        queue_beat(ST_DONE, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_beat();
    grant_beat_t want;
    grant_beat_t got;
    got.status       = out_status;
    got.wake_valid   = out_wake_valid;
    got.wake_thread  = out_wake_thread;
    got.lock_held    = out_lock_held;
    got.owner_thread = out_owner_thread;
    got.last         = out_last;
    if (pending_beats.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected beat: st=%0d wv=%b wt=%h lh=%b ow=%h last=%b",
                 got.status, got.wake_valid, got.wake_thread, got.lock_held,
                 got.owner_thread, got.last);
      fail_count++;
      return;
    end
    want = pending_beats.pop_front();
    if (got.status !== want.status || got.wake_valid !== want.wake_valid ||
        got.wake_thread !== want.wake_thread || got.lock_held !== want.lock_held ||
        got.owner_thread !== want.owner_thread || got.last !== want.last) begin
      if (fail_count < 10) begin
        $display("beat mismatch, expected: st=%0d wv=%b wt=%h lh=%b ow=%h last=%b",
                 want.status, want.wake_valid, want.wake_thread, want.lock_held,
                 want.owner_thread, want.last);
        $display("                 actual: st=%0d wv=%b wt=%h lh=%b ow=%h last=%b",
                 got.status, got.wake_valid, got.wake_thread, got.lock_held,
                 got.owner_thread, got.last);
      end
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      locked = 1'b0;
      owner  = '0;
      mutex_line.delete();
      cond_line.delete();
      pending_beats.delete();
    end else begin
      if (out_valid) check_beat();
      if (start && !busy) grant_step(in_op, in_thread_id);
    end
    beats_left = pending_beats.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import fmcq_pkg::*;

  // Quiet cycles allowed before the run is declared hung: far above the
  // longest sender gap plus the block's latency and a full notify-all burst.
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 200;

  // Op codes the block treats as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_NOTIFY_ALL + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  typedef logic [TID_BITS_DEF-1:0] tid_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [OP_W-1:0] in_op;
  tid_t            in_thread_id;
  logic            out_valid;
  logic [ST_W-1:0] out_status;
  logic            out_wake_valid;
  tid_t            out_wake_thread;
  logic            out_lock_held;
  tid_t            out_owner_thread;
  logic            out_last;

  int fail_count;
  int beats_left;

  // Traffic statistics and the lock state as last reported by the block.
  int   n_taken;
  int   n_done;
  int   n_beats;
  int   n_wakes;
  int   n_full;
  int   burst_len;
  int   longest_burst;
  int   quiet;
  int   counted_items;
  logic seen_locked;
  tid_t seen_owner;
  bit   no_gaps;
  tid_t pool[6];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  fifo_mutex_with_condition_queue DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_thread_id     (in_thread_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_wake_valid   (out_wake_valid),
    .out_wake_thread  (out_wake_thread),
    .out_lock_held    (out_lock_held),
    .out_owner_thread (out_owner_thread),
    .out_last         (out_last)
  );

  fmcq_grant_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_thread_id     (in_thread_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_wake_valid   (out_wake_valid),
    .out_wake_thread  (out_wake_thread),
    .out_lock_held    (out_lock_held),
    .out_owner_thread (out_owner_thread),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .beats_left       (beats_left)
  );

  // Track beats in both directions; the lock state seen here steers the
  // stimulus toward the real owner so unlock and wait get past the checks.
  always @(posedge clk) begin
    if (!rst_n) begin
      n_taken       <= 0;
      n_done        <= 0;
      n_beats       <= 0;
      n_wakes       <= 0;
      n_full        <= 0;
      burst_len     <= 0;
      longest_burst <= 0;
      seen_locked   <= 1'b0;
      seen_owner    <= '0;
    end else begin
      if (start && !busy) n_taken <= n_taken + 1;
      if (out_valid) begin
        n_beats     <= n_beats + 1;
        seen_locked <= out_lock_held;
        seen_owner  <= out_owner_thread;
        if (out_wake_valid) n_wakes <= n_wakes + 1;
        if (out_status == ST_FULL) n_full <= n_full + 1;
        if (out_last) begin
          n_done    <= n_done + 1;
          burst_len <= 0;
          if (burst_len + 1 > longest_burst) longest_burst <= burst_len + 1;
        end else begin
          burst_len <= burst_len + 1;
        end
      end
    end
  end

  // Watchdog: any request or result beat counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Draw from a small set of threads so ids collide, with some fully random.
  function automatic tid_t pick_thread();
    if ($urandom_range(0, 3) == 0) return tid_t'($urandom);
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_LOCK;
    if (r < 50) return OP_UNLOCK;
    if (r < 70) return OP_WAIT;
    if (r < 82) return OP_NOTIFY_ONE;
    if (r < 94) return OP_NOTIFY_ALL;
    return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  // Present one request at a falling edge and hold it until the block takes it.
  // Start stays high on return; the next call or settle() decides what follows.
  task automatic send_req(input logic [OP_W-1:0] op, input tid_t tid);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_thread_id <= tid;
    if (op <= OP_NOTIFY_ALL) counted_items++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every request taken has sent its final beat,
  // so seen_locked and seen_owner are current.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (n_done != n_taken) @(negedge clk);
  endtask

  // Fill the mutex line, then have each owner wait so ownership walks down
  // the line into the condition queue; wake them and unlock until free.
  task automatic fill_and_drain(input int lockers, input int sleepers);
    int i;
    int guard;
    settle();
    if (!seen_locked) send_req(OP_LOCK, pick_thread());
    for (i = 0; i < lockers; i++) send_req(OP_LOCK, tid_t'($urandom));
    for (i = 0; i < sleepers; i++) begin
      settle();
      if (!seen_locked) begin
        send_req(OP_LOCK, pick_thread());
        settle();
      end
      send_req(OP_WAIT, seen_owner);
    end
    if ($urandom_range(0, 3) == 0) repeat (3) send_req(OP_NOTIFY_ONE, pick_thread());
    send_req(OP_NOTIFY_ALL, pick_thread());
    settle();
    guard = 0;
    while (seen_locked && guard < 40) begin
      send_req(OP_UNLOCK, seen_owner);
      settle();
      guard++;
    end
  endtask

  // Random ops; unlock and wait usually come from the last owner seen,
  // sometimes after letting the block drain so that owner is exact.
  task automatic mixed_run(input int n);
    logic [OP_W-1:0] op;
    tid_t            tid;
    int              i;
    for (i = 0; i < n; i++) begin
      op  = pick_op();
      tid = pick_thread();
      if ((op == OP_UNLOCK || op == OP_WAIT) && $urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 1) == 1) settle();
        tid = seen_owner;
      end
      send_req(op, tid);
    end
  endtask

  initial begin
    start        = 1'b0;
    in_op        = OP_LOCK;
    in_thread_id = '0;
    rst_n        = 1'b0;
    no_gaps      = 1'b0;
    foreach (pool[k]) pool[k] = tid_t'($urandom);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every op, spare codes, id extremes, re-lock and non-owner errors.
    send_req(OP_LOCK, 8'h00);          // granted at once
    send_req(OP_LOCK, 8'h00);          // re-lock by the owner
    send_req(OP_LOCK, 8'hFF);          // queued behind the owner
    send_req(OP_UNLOCK, 8'hAA);        // unlock by a non-owner
    send_req(OP_WAIT, 8'h55);          // wait by a non-owner
    send_req(OP_NOTIFY_ONE, 8'h00);    // nobody to wake
    send_req(OP_NOTIFY_ALL, 8'hFF);    // nobody to wake
    send_req(OP_SPARE_LO, 8'h5A);      // ignored codes
    send_req(OP_SPARE_HI, 8'hA5);
    send_req(OP_UNLOCK, 8'h00);        // hand-off to the waiter
    send_req(OP_WAIT, 8'hFF);          // wait with no heir frees the mutex
    send_req(OP_UNLOCK, 8'hFF);        // no longer the owner
    send_req(OP_LOCK, 8'h80);
    send_req(OP_WAIT, 8'h80);
    send_req(OP_NOTIFY_ONE, 8'h11);    // wakes the oldest sleeper only
    send_req(OP_NOTIFY_ALL, 8'h22);    // single-beat sweep
    send_req(OP_LOCK, 8'h01);
    send_req(OP_LOCK, 8'h7F);
    send_req(OP_LOCK, 8'hFE);
    send_req(OP_WAIT, 8'h01);          // wait that hands the mutex on
    send_req(OP_NOTIFY_ALL, 8'h33);
    send_req(OP_UNLOCK, 8'h7F);
    send_req(OP_UNLOCK, 8'hFE);        // last unlock leaves it free

    // Random: start with a run deep enough to fill both queues past the top.
    counted_items = 0;
    fill_and_drain(18, 18);
    while (counted_items < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) foreach (pool[k]) pool[k] = tid_t'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: fill_and_drain($urandom_range(0, 18), $urandom_range(1, 18));
        3, 4, 5, 6, 7: mixed_run($urandom_range(10, 20));
        default: begin
          repeat ($urandom_range(5, 10))
            send_req(OP_W'($urandom_range(0, OP_SPARE_HI)), tid_t'($urandom));
        end
      endcase
    end

    // Drain: every taken request must finish, then allow a little slack
    // for any stray beat.
    settle();
    repeat (20) @(negedge clk);

    $display("Covered %0d requests, %0d result beats, %0d wakeups, %0d queue-full replies;",
             n_taken, n_beats, n_wakes, n_full);
    $display("longest notify-all burst %0d beats, %0d expected beats never arrived.",
             longest_burst, beats_left);
    if (fail_count == 0 && beats_left == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
